// ===== design/pbdo_pkg.sv =====
// ----------------------------------------------------------------------------
// pbdo_pkg
// shared types, constants and codes of the priority buffer with drop-oldest
// ----------------------------------------------------------------------------
package pbdo_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 8;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned CNT_W  = 32;

  // stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 144;
  localparam int unsigned M_USED_W  = 3 + 3 * ID_W + PRIO_W + CNT_W;

  // request codes carried on tuser
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/priority_buffer_drop_oldest_core.sv =====
// ----------------------------------------------------------------------------
// priority_buffer_drop_oldest_core
// fixed-slot request buffer, priority get, smallest-id eviction on full put
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one request: tuser = 0 put, 1 get; tdata holds the
//   id and priority of a put. every request yields exactly one result on the
//   master stream with put/get status, evicted or removed entry and both
//   running counters.
//   a request is taken only while the block is idle. it then reads the slot
//   ram once per slot through one shared comparator stage and writes the
//   result register in its commit step; the next request is accepted only
//   after that commit, so the block does not take a new request before it
//   is through with the last one.
//   the result register lets a request be accepted while the previous result
//   still waits; if the receiver stalls, the block holds in its commit step
//   until the result register frees up.
//   reset empties all slots and clears both counters at once; slot contents
//   need no clearing since valid flags gate every read.
// ----------------------------------------------------------------------------
module priority_buffer_drop_oldest_core #(
  parameter int unsigned CAPACITY = pbdo_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] req_id, [39:32] req_priority
  input  logic [pbdo_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] func
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] put_stored, [1] put_evicted, [33:2] evicted_id, [34] got_valid,
  // [66:35] got_id, [74:67] got_priority, [106:75] served_total,
  // [138:107] declined_total, [143:139] zero
  output logic [pbdo_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);

  pbdo_pkg::ctrl_cmd_t  cmd;
  pbdo_pkg::dp_status_t status;

  pbdo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pbdo_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (s_axis_tuser_i),
    .req_id_i      (s_axis_tdata_i[pbdo_pkg::ID_W-1:0]),
    .req_priority_i(s_axis_tdata_i[pbdo_pkg::ID_W+pbdo_pkg::PRIO_W-1:pbdo_pkg::ID_W]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

// ===== design/pbdo_ram.sv =====
// ----------------------------------------------------------------------------
// pbdo_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pbdo_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/pbdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbdo_ctrl
// sequencer: accept a request, scan all slots, then commit the result
// ----------------------------------------------------------------------------
module pbdo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pbdo_pkg::dp_status_t status_i,
  output pbdo_pkg::ctrl_cmd_t  cmd_o
);

  pbdo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbdo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbdo_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pbdo_pkg::ST_SCAN;
      end
      pbdo_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = pbdo_pkg::ST_FINISH;
      end
      pbdo_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = pbdo_pkg::ST_IDLE;
      end
      default: state_d = pbdo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      pbdo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      pbdo_pkg::ST_SCAN: begin
        cmd_o.step = 1'b1;
      end
      pbdo_pkg::ST_FINISH: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/pbdo_dp.sv =====
// ----------------------------------------------------------------------------
// pbdo_dp
// slot store, scan comparators, counters and result register
// ----------------------------------------------------------------------------
module pbdo_dp #(
  parameter int unsigned CAPACITY = pbdo_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pbdo_pkg::ctrl_cmd_t                 cmd_i,
  output pbdo_pkg::dp_status_t                status_o,
  input  logic                                func_i,
  input  logic [pbdo_pkg::ID_W-1:0]           req_id_i,
  input  logic [pbdo_pkg::PRIO_W-1:0]         req_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pbdo_pkg::M_TDATA_W-1:0]      out_data_o
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SCAN_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W  = pbdo_pkg::ID_W + pbdo_pkg::PRIO_W;

  // latched request
  logic                        op_q;
  logic [pbdo_pkg::ID_W-1:0]   id_q;
  logic [pbdo_pkg::PRIO_W-1:0] prio_q;

  logic [SCAN_W-1:0]   scan_q;
  logic [CAPACITY-1:0] valid_q;

  logic                        free_have_q, vic_have_q, best_have_q;
  logic [IDX_W-1:0]            free_idx_q, vic_idx_q, best_idx_q;
  logic [pbdo_pkg::ID_W-1:0]   vic_id_q, best_id_q;
  logic [pbdo_pkg::PRIO_W-1:0] best_prio_q;

  logic [pbdo_pkg::CNT_W-1:0] served_q, declined_q;

  logic                          m_valid_q;
  logic [pbdo_pkg::M_USED_W-1:0] m_data_q;

  // ram interface
  logic                        rd_en, wr_en;
  logic [IDX_W-1:0]            rd_addr, wr_addr, cmp_idx;
  logic [ENT_W-1:0]            rd_data;
  logic [pbdo_pkg::ID_W-1:0]   ent_id;
  logic [pbdo_pkg::PRIO_W-1:0] ent_prio;
  logic                        ent_valid, cmp_en;

  logic scan_at_end;

  assign scan_at_end = (scan_q == SCAN_W'(CAPACITY));
  assign rd_en       = cmd_i.step && !scan_at_end;
  assign rd_addr     = scan_q[IDX_W-1:0];
  assign cmp_en      = cmd_i.step && (scan_q != '0);
  assign cmp_idx     = IDX_W'(scan_q - 1'b1);
  assign ent_id      = rd_data[pbdo_pkg::ID_W-1:0];
  assign ent_prio    = rd_data[ENT_W-1:pbdo_pkg::ID_W];
  assign ent_valid   = valid_q[cmp_idx];

  assign wr_en   = cmd_i.commit && (op_q == pbdo_pkg::FUNC_PUT);
  assign wr_addr = free_have_q ? free_idx_q : vic_idx_q;

  pbdo_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i({prio_q, id_q}),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign status_o.scan_done = scan_at_end;
  assign status_o.out_free  = !m_valid_q || out_ready_i;

  // request latch and scan trackers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= func_i;
      id_q   <= req_id_i;
      prio_q <= req_priority_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      free_have_q <= 1'b0;
      vic_have_q  <= 1'b0;
      best_have_q <= 1'b0;
      free_idx_q  <= '0;
      vic_idx_q   <= '0;
      best_idx_q  <= '0;
      vic_id_q    <= '0;
      best_id_q   <= '0;
      best_prio_q <= '0;
    end else if (cmd_i.start) begin
      scan_q      <= '0;
      free_have_q <= 1'b0;
      vic_have_q  <= 1'b0;
      best_have_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (!scan_at_end) scan_q <= SCAN_W'(scan_q + 1'b1);
      if (cmp_en) begin
        // lowest free slot
        if (!ent_valid && !free_have_q) begin
          free_have_q <= 1'b1;
          free_idx_q  <= cmp_idx;
        end
        // smallest id, lowest index on ties
        if (ent_valid && (!vic_have_q || ent_id < vic_id_q)) begin
          vic_have_q <= 1'b1;
          vic_idx_q  <= cmp_idx;
          vic_id_q   <= ent_id;
        end
        // highest priority, then larger id, then higher index
        if (ent_valid && (!best_have_q || ent_prio > best_prio_q ||
            (ent_prio == best_prio_q && ent_id >= best_id_q))) begin
          best_have_q <= 1'b1;
          best_idx_q  <= cmp_idx;
          best_id_q   <= ent_id;
          best_prio_q <= ent_prio;
        end
      end
    end
  end

  // commit: slot flags, counters, result register
  logic                          put_stored, put_evicted, got_valid;
  logic [pbdo_pkg::CNT_W-1:0]    served_d, declined_d;
  logic [pbdo_pkg::ID_W-1:0]     evicted_id, got_id;
  logic [pbdo_pkg::PRIO_W-1:0]   got_prio;

  always_comb begin
    put_stored  = 1'b0;
    put_evicted = 1'b0;
    got_valid   = 1'b0;
    evicted_id  = '0;
    got_id      = '0;
    got_prio    = '0;
    served_d    = served_q;
    declined_d  = declined_q;
    if (op_q == pbdo_pkg::FUNC_PUT) begin
      if (free_have_q) begin
        put_stored = 1'b1;
      end else begin
        put_evicted = 1'b1;
        evicted_id  = vic_id_q;
        declined_d  = declined_q + 1'b1;
      end
    end else if (best_have_q) begin
      got_valid = 1'b1;
      got_id    = best_id_q;
      got_prio  = best_prio_q;
      served_d  = served_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      served_q   <= '0;
      declined_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        if (op_q == pbdo_pkg::FUNC_PUT) begin
          valid_q[wr_addr] <= 1'b1;
        end else if (best_have_q) begin
          valid_q[best_idx_q] <= 1'b0;
        end
        served_q   <= served_d;
        declined_q <= declined_d;
        m_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_q <= {declined_d, served_d, got_prio, got_id, got_valid,
                   evicted_id, put_evicted, put_stored};
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = {{(pbdo_pkg::M_TDATA_W - pbdo_pkg::M_USED_W){1'b0}}, m_data_q};

endmodule
